FILE: hw/rtl/lruvc_pkg.sv
// Shared types and constants for the two-way LRU cache with victim buffer.
// No dependencies; used by lruvc_ctrl, lruvc_dp and the top level.
package lruvc_pkg;

    localparam int DEF_SET_COUNT         = 32;
    localparam int DEF_BLOCK_OFFSET_BITS = 6;
    localparam int DEF_ADDRESS_BITS      = 32;

    localparam int OUTCOME_W = 2;

    localparam logic [OUTCOME_W-1:0] OUT_MAIN_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_VICTIM_HIT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_FILL  = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_EVICT = 2'd3;

    typedef struct packed {
        logic clear_wr;   // clearing pass: write one set of tag/LRU memories
        logic load;       // capture the incoming address
        logic read;       // read the set from the tag and LRU memories
        logic resolve;    // decide, update state, emit the result
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last; // clearing pass is at its last set
        logic set_ready;  // set index is valid
    } ctrl_sts_t;

endpackage

FILE: hw/rtl/lruvc_ctrl.sv
// Controller state machine for the two-way LRU cache with victim buffer.
// Depends on lruvc_pkg for the command and status structs.
module lruvc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lruvc_pkg::ctrl_sts_t  sts,
    output lruvc_pkg::ctrl_cmd_t  cmd,
    output logic                  busy
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_REDUCE = 2'd2;
    localparam logic [1:0] S_CMP    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (sts.set_ready)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.clear_wr = (state_reg == S_CLEAR);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.read     = (state_reg == S_REDUCE) && sts.set_ready;
    assign cmd.resolve  = (state_reg == S_CMP);

    // the set is always read from memory in the cycle before it is resolved
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |-> $past(cmd.read))
        else $error("resolve without a preceding set read");

endmodule

FILE: hw/rtl/lruvc_dp.sv
// Datapath: set index, tag/LRU memories, victim buffer, miss counter, results.
// Depends on lruvc_pkg; driven by lruvc_ctrl commands.
module lruvc_dp
#(
    parameter int SET_COUNT         = lruvc_pkg::DEF_SET_COUNT,
    parameter int BLOCK_OFFSET_BITS = lruvc_pkg::DEF_BLOCK_OFFSET_BITS,
    parameter int ADDRESS_BITS      = lruvc_pkg::DEF_ADDRESS_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lruvc_pkg::ctrl_cmd_t               cmd,
    output lruvc_pkg::ctrl_sts_t               sts,
    input  logic [ADDRESS_BITS-1:0]            mem_address,
    output logic                               done,
    output logic [lruvc_pkg::OUTCOME_W-1:0]    outcome,
    output logic [31:0]                        miss_total
);

    localparam int BLK_W = ADDRESS_BITS - BLOCK_OFFSET_BITS;
    localparam int SET_W = $clog2(SET_COUNT);
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

    logic [BLK_W-1:0]  block_reg;
    logic [SET_W-1:0]  set_idx;
    logic [SET_W-1:0]  clr_cnt_reg;

    // tag memories hold {valid, block}
    logic [BLK_W:0]    way0_mem [SET_COUNT];
    logic [BLK_W:0]    way1_mem [SET_COUNT];
    logic              lru_mem  [SET_COUNT];
    logic [BLK_W:0]    way0_rd_reg;
    logic [BLK_W:0]    way1_rd_reg;
    logic              lru_rd_reg;

    logic [BLK_W-1:0]  vb_reg [2];
    logic [1:0]        vv_reg;
    logic [31:0]       miss_cnt_reg;
    logic              done_reg;
    logic [lruvc_pkg::OUTCOME_W-1:0] outcome_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            block_reg <= mem_address[ADDRESS_BITS-1:BLOCK_OFFSET_BITS];
        end
    end

    // set index = block mod SET_COUNT
    generate
        if ((1 << SET_W) == SET_COUNT)
        begin : g_pow2
            assign set_idx       = block_reg[SET_W-1:0];
            assign sts.set_ready = 1'b1;
        end
        else
        begin : g_serial
            // byte-weighted sum of the block (each weight is 256^i mod SET_COUNT),
            // then a reciprocal multiply and one correction bring it below SET_COUNT
            localparam int NBYTES = (BLK_W + 7) / 8;
            localparam int PAD_W  = NBYTES * 8;
            localparam int SUM_W  = SET_W + 8 + $clog2(NBYTES);
            localparam int K_W    = SUM_W - SET_W + 1;
            localparam int PROD_W = SUM_W + K_W;
            localparam logic [K_W-1:0] RECIP_K = K_W'((1 << SUM_W) / SET_COUNT);
            localparam logic [SET_W:0] MODULUS = (SET_W + 1)'(SET_COUNT);
            localparam logic [1:0] STEP_SUM   = 2'd0;
            localparam logic [1:0] STEP_RECIP = 2'd1;
            localparam logic [1:0] STEP_FIX   = 2'd2;
            localparam logic [1:0] STEP_DONE  = 2'd3;

            function automatic int byte_weight(input int idx);
                int w;
                w = 1 % SET_COUNT;
                for (int k = 0; k < idx; k++)
                begin
                    w = (w * 256) % SET_COUNT;
                end
                return w;
            endfunction

            logic [PAD_W-1:0]  blk_pad;
            logic [SUM_W-1:0]  partial [NBYTES+1];
            logic [SUM_W-1:0]  sum_reg;
            logic [PROD_W-1:0] prod;
            logic [K_W-1:0]    q_reg;
            logic [SUM_W-1:0]  qm;
            logic [SUM_W-1:0]  diff;
            logic [SET_W:0]    trial;
            logic [SET_W:0]    reduced;
            logic [SET_W-1:0]  rem_reg;
            logic [1:0]        step_reg;

            assign blk_pad    = PAD_W'(block_reg);
            assign partial[0] = '0;

            for (genvar gi = 0; gi < NBYTES; gi++)
            begin : g_byte
                localparam logic [SUM_W-1:0] WEIGHT = SUM_W'(byte_weight(gi));
                assign partial[gi+1] = partial[gi] + SUM_W'(blk_pad[gi*8 +: 8]) * WEIGHT;
            end

            // quotient estimate is low by at most one, so the remainder is below 2M
            assign prod    = PROD_W'(sum_reg) * PROD_W'(RECIP_K);
            assign qm      = SUM_W'(q_reg) * SUM_W'(SET_COUNT);
            assign diff    = sum_reg - qm;
            assign trial   = diff[SET_W:0];
            assign reduced = (trial >= MODULUS) ? (trial - MODULUS) : trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= STEP_DONE;
                end
                else if (cmd.load)
                begin
                    step_reg <= STEP_SUM;
                end
                else if (step_reg != STEP_DONE)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (step_reg == STEP_SUM)
                begin
                    sum_reg <= partial[NBYTES];
                end
                if (step_reg == STEP_RECIP)
                begin
                    q_reg <= prod[PROD_W-1:SUM_W];
                end
                if (step_reg == STEP_FIX)
                begin
                    rem_reg <= reduced[SET_W-1:0];
                end
            end

            assign set_idx       = rem_reg;
            assign sts.set_ready = (step_reg == STEP_DONE);
        end
    endgenerate

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == SET_LAST);

    // lookup decision
    logic             v0, v1, h0, h1, lru;
    logic [BLK_W-1:0] evicted;
    logic             vhit0, vhit1;
    logic             way0_we, way1_we, is_miss;
    logic             lru_wdata;
    logic [lruvc_pkg::OUTCOME_W-1:0] outcome_next;

    assign v0    = way0_rd_reg[BLK_W];
    assign v1    = way1_rd_reg[BLK_W];
    assign h0    = v0 && (way0_rd_reg[BLK_W-1:0] == block_reg);
    assign h1    = v1 && (way1_rd_reg[BLK_W-1:0] == block_reg);
    assign lru   = lru_rd_reg;
    assign evicted = lru ? way1_rd_reg[BLK_W-1:0] : way0_rd_reg[BLK_W-1:0];
    assign vhit0 = vv_reg[0] && (vb_reg[0] == block_reg);
    assign vhit1 = vv_reg[1] && (vb_reg[1] == block_reg);

    always_comb
    begin
        way0_we      = 1'b0;
        way1_we      = 1'b0;
        is_miss      = 1'b0;
        lru_wdata    = 1'b0;
        outcome_next = lruvc_pkg::OUT_MAIN_HIT;
        if (!v0)
        begin
            way0_we      = 1'b1;
            lru_wdata    = 1'b1;
            is_miss      = 1'b1;
            outcome_next = lruvc_pkg::OUT_MISS_FILL;
        end
        else if (h0)
        begin
            lru_wdata    = 1'b1;
        end
        else if (!v1)
        begin
            way1_we      = 1'b1;
            is_miss      = 1'b1;
            outcome_next = lruvc_pkg::OUT_MISS_FILL;
        end
        else if (h1)
        begin
            lru_wdata    = 1'b0;
        end
        else
        begin
            way0_we   = !lru;
            way1_we   = lru;
            lru_wdata = !lru;
            if (vhit0 || vhit1)
            begin
                outcome_next = lruvc_pkg::OUT_VICTIM_HIT;
            end
            else
            begin
                is_miss      = 1'b1;
                outcome_next = lruvc_pkg::OUT_MISS_EVICT;
            end
        end
    end

    // tag and LRU memories
    logic [SET_W-1:0] wr_addr;
    logic [BLK_W:0]   way_wdata;

    assign wr_addr   = cmd.clear_wr ? clr_cnt_reg : set_idx;
    assign way_wdata = cmd.clear_wr ? '0 : {1'b1, block_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            way0_rd_reg <= way0_mem[set_idx];
            way1_rd_reg <= way1_mem[set_idx];
            lru_rd_reg  <= lru_mem[set_idx];
        end
        if (cmd.clear_wr || (cmd.resolve && way0_we))
        begin
            way0_mem[wr_addr] <= way_wdata;
        end
        if (cmd.clear_wr || (cmd.resolve && way1_we))
        begin
            way1_mem[wr_addr] <= way_wdata;
        end
        if (cmd.clear_wr || cmd.resolve)
        begin
            lru_mem[wr_addr] <= cmd.clear_wr ? 1'b0 : lru_wdata;
        end
    end

    // victim buffer, only touched on a conflict in a full set
    logic conflict;
    assign conflict = cmd.resolve && v0 && v1 && !h0 && !h1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg <= '0;
        end
        else if (conflict)
        begin
            if (vhit0 || vhit1)
            begin
                vv_reg <= {1'b1, vhit0 ? vv_reg[1] : vv_reg[0]};
            end
            else if (!vv_reg[0])
            begin
                vv_reg[0] <= 1'b1;
            end
            else
            begin
                vv_reg[1] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (conflict)
        begin
            if (vhit0 || vhit1)
            begin
                if (vhit0)
                begin
                    vb_reg[0] <= vb_reg[1];
                end
                vb_reg[1] <= evicted;
            end
            else if (!vv_reg[0])
            begin
                vb_reg[0] <= evicted;
            end
            else if (!vv_reg[1])
            begin
                vb_reg[1] <= evicted;
            end
            else
            begin
                vb_reg[0] <= vb_reg[1];
                vb_reg[1] <= evicted;
            end
        end
    end

    // miss counter and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
            outcome_reg  <= lruvc_pkg::OUT_MAIN_HIT;
        end
        else
        begin
            done_reg <= cmd.resolve;
            if (cmd.resolve)
            begin
                outcome_reg <= outcome_next;
                if (is_miss && (miss_cnt_reg != '1))
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign outcome    = outcome_reg;
    assign miss_total = miss_cnt_reg;

    a_hit_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (outcome == lruvc_pkg::OUT_MAIN_HIT || outcome == lruvc_pkg::OUT_VICTIM_HIT)
        |-> miss_cnt_reg == $past(miss_cnt_reg))
        else $error("miss counter moved on a hit");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (outcome == lruvc_pkg::OUT_MISS_FILL || outcome == lruvc_pkg::OUT_MISS_EVICT)
        |-> (miss_cnt_reg == $past(miss_cnt_reg) + 32'd1 || miss_cnt_reg == '1))
        else $error("miss not counted");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> miss_cnt_reg == $past(miss_cnt_reg))
        else $error("miss counter changed outside a transaction");

endmodule

FILE: hw/rtl/two_way_lru_cache_with_victim_buffer.sv
// Top level: two-way set-associative LRU cache model with a two-entry victim buffer.
// Depends on lruvc_pkg, lruvc_ctrl and lruvc_dp.
//
// One address per transaction: start is taken when busy is low. After reset the
// block clears its tag and LRU memories, one set at a time, with busy high.
// With a power-of-two SET_COUNT an access runs capture, memory read and resolve;
// otherwise the set index is first formed by a weighted byte sum, a reciprocal
// multiply and a correction before the memory read. The result (outcome,
// miss_total) is shown for one cycle with done high, and must be taken then; the
// receiver cannot stall. miss_total holds its value until the next access resolves.
module two_way_lru_cache_with_victim_buffer
#(
    parameter int SET_COUNT         = lruvc_pkg::DEF_SET_COUNT,
    parameter int BLOCK_OFFSET_BITS = lruvc_pkg::DEF_BLOCK_OFFSET_BITS,
    parameter int ADDRESS_BITS      = lruvc_pkg::DEF_ADDRESS_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ADDRESS_BITS-1:0]           mem_address,
    output logic                              done,
    output logic [lruvc_pkg::OUTCOME_W-1:0]   outcome,
    output logic [31:0]                       miss_total
);

    lruvc_pkg::ctrl_cmd_t cmd;
    lruvc_pkg::ctrl_sts_t sts;

    lruvc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lruvc_dp
    #(
        .SET_COUNT         (SET_COUNT),
        .BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS),
        .ADDRESS_BITS      (ADDRESS_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mem_address (mem_address),
        .done        (done),
        .outcome     (outcome),
        .miss_total  (miss_total)
    );

endmodule

FILE: verif/two_way_lru_cache_with_victim_buffer_test.sv
`timescale 1ns / 1ps
// Testbench for two_way_lru_cache_with_victim_buffer: directed and random address streams,
// each result checked against a cache predictor kept in a scoreboard class.
// Depends on lruvc_pkg and the two_way_lru_cache_with_victim_buffer RTL.

class cache_scoreboard;

    logic [25:0] tag_store [64];
    bit          tag_valid [64];
    bit          lru_bit   [32];
    logic [25:0] victim_tag   [2];
    bit          victim_valid [2];
    logic [31:0] miss_count;

    logic [1:0]  want_outcome [$];
    logic [31:0] want_misses  [$];
    int          fail_count;

    function new();
        for (int i = 0; i < 64; i++)
        begin
            tag_store[i] = '0;
            tag_valid[i] = 1'b0;
        end
        for (int i = 0; i < 32; i++)
            lru_bit[i] = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            victim_tag[i]   = '0;
            victim_valid[i] = 1'b0;
        end
        miss_count = '0;
        fail_count = 0;
    endfunction

    function int pending();
        return want_outcome.size();
    endfunction

    function void bump_misses();
        if (miss_count != 32'hFFFF_FFFF)
            miss_count++;
    endfunction

    // Runs one access through the predicted cache and queues its result.
    function void note_access(logic [31:0] addr);
        logic [25:0] blk;
        logic [4:0]  set_idx;
        logic [5:0]  w0;
        logic [5:0]  w1;
        logic [5:0]  slot;
        bit          vic;
        logic [25:0] evicted;
        bit          hit0;
        bit          hit1;
        bit          other;
        logic [25:0] other_tag;
        bit          other_ok;
        logic [1:0]  result;

        blk     = addr[31:6];
        set_idx = blk[4:0];
        w0      = {set_idx, 1'b0};
        w1      = {set_idx, 1'b1};
        if (!tag_valid[w0])
        begin
            tag_store[w0] = blk;
            tag_valid[w0] = 1'b1;
            lru_bit[set_idx] = 1'b1;
            bump_misses();
            result = lruvc_pkg::OUT_MISS_FILL;
        end
        else if (tag_store[w0] == blk)
        begin
            lru_bit[set_idx] = 1'b1;
            result = lruvc_pkg::OUT_MAIN_HIT;
        end
        else if (!tag_valid[w1])
        begin
            tag_store[w1] = blk;
            tag_valid[w1] = 1'b1;
            lru_bit[set_idx] = 1'b0;
            bump_misses();
            result = lruvc_pkg::OUT_MISS_FILL;
        end
        else if (tag_store[w1] == blk)
        begin
            lru_bit[set_idx] = 1'b0;
            result = lruvc_pkg::OUT_MAIN_HIT;
        end
        else
        begin
            vic     = lru_bit[set_idx];
            slot    = {set_idx, vic};
            evicted = tag_store[slot];
            hit0    = victim_valid[0] && victim_tag[0] == blk;
            hit1    = victim_valid[1] && victim_tag[1] == blk;
            if (hit0 || hit1)
            begin
                // surviving entry moves to the front, the evicted block goes behind it
                other     = hit0;
                other_tag = victim_tag[other];
                other_ok  = victim_valid[other];
                victim_tag[0]   = other_tag;
                victim_valid[0] = other_ok;
                victim_tag[1]   = evicted;
                victim_valid[1] = 1'b1;
                result = lruvc_pkg::OUT_VICTIM_HIT;
            end
            else
            begin
                if (!victim_valid[0])
                begin
                    victim_tag[0]   = evicted;
                    victim_valid[0] = 1'b1;
                end
                else if (!victim_valid[1])
                begin
                    victim_tag[1]   = evicted;
                    victim_valid[1] = 1'b1;
                end
                else
                begin
                    victim_tag[0] = victim_tag[1];
                    victim_tag[1] = evicted;
                end
                bump_misses();
                result = lruvc_pkg::OUT_MISS_EVICT;
            end
            tag_store[slot]  = blk;
            lru_bit[set_idx] = ~vic;
        end
        want_outcome.push_back(result);
        want_misses.push_back(miss_count);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function void check_result(logic [1:0] got_outcome, logic [31:0] got_misses);
        logic [1:0]  exp_o;
        logic [31:0] exp_m;

        if (want_outcome.size() == 0)
        begin
            flag("result with no access pending", '0, {30'd0, got_outcome});
            return;
        end
        exp_o = want_outcome.pop_front();
        exp_m = want_misses.pop_front();
        if (got_outcome !== exp_o)
            flag("outcome", {30'd0, exp_o}, {30'd0, got_outcome});
        if (got_misses !== exp_m)
            flag("miss_total", exp_m, got_misses);
    endfunction

endclass

module two_way_lru_cache_with_victim_buffer_test;

    localparam int RANDOM_ACCESSES = 800;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [31:0] mem_address = '0;
    logic        busy;
    logic        done;
    logic [1:0]  outcome;
    logic [31:0] miss_total;

    int          cycle_count = 0;
    logic [20:0] tag_pool [6];

    cache_scoreboard sb = new();

    two_way_lru_cache_with_victim_buffer i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mem_address (mem_address),
        .done        (done),
        .outcome     (outcome),
        .miss_total  (miss_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // done is one cycle wide; values read here are the ones before this edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(outcome, miss_total);
    end

    // Holds start high until the block takes the transaction.
    task automatic send_access(input logic [31:0] addr);
        start       <= 1'b1;
        mem_address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.note_access(addr);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly a few hot sets and a small tag pool so that sets fill, evict and
    // hit in the victim buffer; the rest spreads pool tags over all sets or is fully random.
    function automatic logic [31:0] pick_address();
        int          r;
        logic [4:0]  set_idx;
        logic [5:0]  offset;

        r      = $urandom_range(0, 99);
        offset = 6'($urandom_range(0, 63));
        if (r < 10)
            return $urandom();
        if (r < 25)
            set_idx = 5'($urandom_range(0, 31));
        else
            set_idx = 5'($urandom_range(0, 3));
        return {tag_pool[3'($urandom_range(0, 5))], set_idx, offset};
    endfunction

    initial
    begin
        logic [31:0] directed [22];
        int          sent;
        int          burst;

        // set 0: fill both ways, hit both, evict into an empty then a full victim
        // buffer, hit victim slot 0 and slot 1; then address extremes
        directed = '{32'h0000_0000, 32'h0000_003F, 32'h0000_0800, 32'h0000_0815,
                     32'h0000_1000, 32'h0000_1800, 32'h0000_2000, 32'h0000_0800,
                     32'h0000_1800, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_F7C0, 32'hFFFF_F7FF, 32'h0000_2000, 32'h0000_1000,
                     32'h0000_0800, 32'h0000_0040};
        for (int i = 0; i < 6; i++)
            tag_pool[i] = 21'($urandom());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_access(directed[i]);
            if (i % 5 == 4)
                idle_cycles($urandom_range(1, 4));
        end
        wait_all_results();

        sent = 0;
        while (sent < RANDOM_ACCESSES)
        begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_ACCESSES; k++)
            begin
                send_access(pick_address());
                sent++;
                if (sent % 100 == 0)
                    tag_pool[3'($urandom_range(0, 5))] = 21'($urandom());
                if (sent % 250 == 0)
                    wait_all_results();
            end
            // roughly a third of bursts run straight into the next one
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
